// ===== design/rsf_pkg.sv =====
package rsf_pkg;

    typedef struct packed {
        logic [15:0] pixel_in;
        logic        frame_end;
    } in_word_t;

    typedef struct packed {
        logic [15:0] pixel_out;
        logic [4:0]  level_used;
        logic        frame_last;
        logic        fade_done;
    } out_word_t;

    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned FactorWidth   = 13;

    localparam logic [CfgIndexWidth-1:0] CFG_RED_MASK       = 3'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_GREEN_MASK     = 3'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_BLUE_MASK      = 3'd2;
    localparam logic [CfgIndexWidth-1:0] CFG_RED_SHIFT      = 3'd3;
    localparam logic [CfgIndexWidth-1:0] CFG_GREEN_SHIFT    = 3'd4;
    localparam logic [CfgIndexWidth-1:0] CFG_FADE_DIRECTION = 3'd5;
    localparam logic [CfgIndexWidth-1:0] CFG_LEVEL_STEP     = 3'd6;

    localparam logic [4:0] LEVEL_TOP = 5'd31;

    // i * (80 + i * (32 - i)) for i = level + 1
    localparam logic [FactorWidth-1:0] CURVE_FACTOR [32] = '{
        13'd111,  13'd280,  13'd501,  13'd768,  13'd1075, 13'd1416, 13'd1785, 13'd2176,
        13'd2583, 13'd3000, 13'd3421, 13'd3840, 13'd4251, 13'd4648, 13'd5025, 13'd5376,
        13'd5695, 13'd5976, 13'd6213, 13'd6400, 13'd6531, 13'd6600, 13'd6601, 13'd6528,
        13'd6375, 13'd6136, 13'd5805, 13'd5376, 13'd4843, 13'd4200, 13'd3441, 13'd2560
    };

    // floor(x / 5) for x below 2**20
    localparam logic [20:0] DIV5_RECIP = 21'd1677722;

endpackage

// ===== design/rsf_scale.sv =====
module rsf_scale (
    input  logic        clk,
    input  logic        load,
    input  logic [15:0] comp,
    input  logic [rsf_pkg::FactorWidth-1:0] factor,
    input  logic [15:0] limit,
    output logic [15:0] result
);
    import rsf_pkg::*;

    logic [28:0] product_reg;
    logic [19:0] scaled_512;
    logic [40:0] recip_prod;
    logic [17:0] quotient;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            product_reg <= comp * factor;
        end
    end

    // divide by 2560: drop nine bits, then divide by five
    assign scaled_512 = product_reg[28:9];
    assign recip_prod = scaled_512 * DIV5_RECIP;
    assign quotient   = recip_prod[40:23];

    assign result = (quotient > {2'b00, limit}) ? limit : quotient[15:0];

endmodule

// ===== design/rgb16_shade_fade.sv =====
// rgb16_shade_fade: brightness fade over a stream of packed 16-bit pixels.
// Input words (in_data) and result words (out_data) move on valid/ready
// channels; one result word comes out for every input word, in order.
// The cfg_we/cfg_index/cfg_data port writes the masks, shifts, fade direction
// and level step; write it only while no word is in flight.
// From input accept to out_valid a word passes these registers in order: an
// input register holding the shade level and curve factor, loaded on accept,
// a product register after the component multipliers, and the result register
// after the divide by 2560.
// Throughput is one word per clock while out_ready stays high; each stage
// advances whenever the stage after it is empty or moving, so a stalled
// receiver backs up the three stages before in_ready drops.
// The shade level is decided on input accept; a frame end steps it for the
// next frame and flags fade_done on the last frame of a fade.
// Reset empties the pipeline, loads the configuration defaults (RGB565 masks,
// fade in, step two) and leaves the fade sequence idle, so the next word
// starts a new fade.
module rgb16_shade_fade (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rsf_pkg::in_word_t     in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rsf_pkg::out_word_t    out_data,
    input  logic                  cfg_we,
    input  logic [rsf_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [15:0]           cfg_data
);
    import rsf_pkg::*;

    logic [15:0] red_mask_reg;
    logic [15:0] green_mask_reg;
    logic [15:0] blue_mask_reg;
    logic [3:0]  red_shift_reg;
    logic [3:0]  green_shift_reg;
    logic        fade_direction_reg;
    logic [4:0]  level_step_reg;

    logic [4:0]  shade_level_reg;
    logic [4:0]  shade_level_next;
    logic        sequence_idle_reg;
    logic        sequence_idle_next;

    logic        s0_valid_reg;
    logic [15:0] s0_pixel_reg;
    logic [4:0]  s0_level_reg;
    logic        s0_frame_end_reg;
    logic        s0_done_reg;
    logic [FactorWidth-1:0] s0_factor_reg;

    logic        s1_valid_reg;
    logic [4:0]  s1_level_reg;
    logic        s1_frame_end_reg;
    logic        s1_done_reg;

    logic        s2_valid_reg;
    out_word_t   s2_word_reg;

    logic        en0;
    logic        en1;
    logic        en2;
    logic        accept;

    logic [4:0]  level_cur;
    logic [4:0]  step_eff;
    logic [5:0]  level_sum;
    logic        done_cur;

    logic [15:0] red_comp;
    logic [15:0] green_comp;
    logic [15:0] blue_comp;
    logic [15:0] red_scaled;
    logic [15:0] green_scaled;
    logic [15:0] blue_scaled;
    logic [15:0] red_limit;
    logic [15:0] green_limit;
    logic [15:0] packed_pixel;

    assign en2      = !s2_valid_reg || out_ready;
    assign en1      = !s1_valid_reg || en2;
    assign en0      = !s0_valid_reg || en1;
    assign in_ready = en0;
    assign accept   = in_valid && en0;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_mask_reg       <= 16'hF800;
            green_mask_reg     <= 16'h07E0;
            blue_mask_reg      <= 16'h001F;
            red_shift_reg      <= 4'd11;
            green_shift_reg    <= 4'd5;
            fade_direction_reg <= 1'b0;
            level_step_reg     <= 5'd2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RED_MASK:       red_mask_reg       <= cfg_data;
                CFG_GREEN_MASK:     green_mask_reg     <= cfg_data;
                CFG_BLUE_MASK:      blue_mask_reg      <= cfg_data;
                CFG_RED_SHIFT:      red_shift_reg      <= cfg_data[3:0];
                CFG_GREEN_SHIFT:    green_shift_reg    <= cfg_data[3:0];
                CFG_FADE_DIRECTION: fade_direction_reg <= cfg_data[0];
                CFG_LEVEL_STEP:     level_step_reg     <= cfg_data[4:0];
                default:            ;
            endcase
        end
    end

    // shade level for the word on the input, and the level for the next frame
    always_comb
    begin
        if (sequence_idle_reg)
        begin
            level_cur = fade_direction_reg ? LEVEL_TOP : 5'd0;
        end
        else
        begin
            level_cur = shade_level_reg;
        end

        step_eff  = (level_step_reg == 5'd0) ? 5'd1 : level_step_reg;
        level_sum = {1'b0, level_cur} + {1'b0, step_eff};

        done_cur           = 1'b0;
        shade_level_next   = level_cur;
        sequence_idle_next = 1'b0;

        if (in_data.frame_end)
        begin
            if (fade_direction_reg)
            begin
                if (level_cur < step_eff)
                begin
                    done_cur = 1'b1;
                end
                else
                begin
                    shade_level_next = level_cur - step_eff;
                end
            end
            else
            begin
                if (level_sum > {1'b0, LEVEL_TOP})
                begin
                    done_cur = 1'b1;
                end
                else
                begin
                    shade_level_next = level_sum[4:0];
                end
            end
            sequence_idle_next = done_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shade_level_reg   <= 5'd0;
            sequence_idle_reg <= 1'b1;
        end
        else if (accept)
        begin
            shade_level_reg   <= shade_level_next;
            sequence_idle_reg <= sequence_idle_next;
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (en0)
            begin
                s0_valid_reg <= in_valid;
            end
            if (en1)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_pixel_reg     <= in_data.pixel_in;
            s0_level_reg     <= level_cur;
            s0_frame_end_reg <= in_data.frame_end;
            s0_done_reg      <= done_cur;
            s0_factor_reg    <= CURVE_FACTOR[level_cur];
        end
    end

    assign red_comp   = (s0_pixel_reg & red_mask_reg) >> red_shift_reg;
    assign green_comp = (s0_pixel_reg & green_mask_reg) >> green_shift_reg;
    assign blue_comp  = s0_pixel_reg & blue_mask_reg;

    assign red_limit   = red_mask_reg >> red_shift_reg;
    assign green_limit = green_mask_reg >> green_shift_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_level_reg     <= s0_level_reg;
            s1_frame_end_reg <= s0_frame_end_reg;
            s1_done_reg      <= s0_done_reg;
        end
    end

    rsf_scale u_scale_red (
        .clk    (clk),
        .load   (en1),
        .comp   (red_comp),
        .factor (s0_factor_reg),
        .limit  (red_limit),
        .result (red_scaled)
    );

    rsf_scale u_scale_green (
        .clk    (clk),
        .load   (en1),
        .comp   (green_comp),
        .factor (s0_factor_reg),
        .limit  (green_limit),
        .result (green_scaled)
    );

    rsf_scale u_scale_blue (
        .clk    (clk),
        .load   (en1),
        .comp   (blue_comp),
        .factor (s0_factor_reg),
        .limit  (blue_mask_reg),
        .result (blue_scaled)
    );

    assign packed_pixel = (red_scaled << red_shift_reg)
                        | (green_scaled << green_shift_reg)
                        | blue_scaled;

    // result register
    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_word_reg.pixel_out  <= packed_pixel;
            s2_word_reg.level_used <= s1_level_reg;
            s2_word_reg.frame_last <= s1_frame_end_reg;
            s2_word_reg.fade_done  <= s1_done_reg;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_word_reg;

endmodule

// ===== verif/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rsf_pkg::*;

    localparam int unsigned CURVE_BASE     = 80;
    localparam int unsigned CURVE_SPAN     = 32;
    localparam int unsigned CURVE_DIV      = 2560;
    localparam int unsigned PIPE_DRAIN     = 4;
    localparam int unsigned SQUEEZE_CYCLES = 60;
    localparam int unsigned PHASE_COUNT    = 8;
    localparam int unsigned PHASE_WORDS    = 112;
    localparam int unsigned CYCLE_LIMIT    = 300000;

    localparam logic [CfgIndexWidth-1:0] CFG_NONE = 3'd7;
    localparam logic FADE_IN  = 1'b0;
    localparam logic FADE_OUT = 1'b1;

    localparam in_word_t  NO_WORD = '0;
    localparam out_word_t NO_WANT = '0;

    typedef struct packed {
        logic                     is_cfg;
        logic [CfgIndexWidth-1:0] idx;
        logic [15:0]              val;
        in_word_t                 word;
        logic                     typed;
        out_word_t                want;
    } probe_row_t;

    localparam int unsigned PROBE_ROWS = 24;
    localparam probe_row_t PROBES [PROBE_ROWS] = '{
        '{1'b0, CFG_NONE, 16'h0, '{16'hFFFF, 1'b0}, 1'b1, '{16'h0841, 5'd0, 1'b0, 1'b0}},
        '{1'b0, CFG_NONE, 16'h0, '{16'h0000, 1'b1}, 1'b1, '{16'h0000, 5'd0, 1'b1, 1'b0}},
        '{1'b1, CFG_LEVEL_STEP, 16'd31, NO_WORD, 1'b0, NO_WANT},
        '{1'b0, CFG_NONE, 16'h0, '{16'hFFFF, 1'b1}, 1'b0, NO_WANT},
        '{1'b0, CFG_NONE, 16'h0, '{16'hA5A5, 1'b1}, 1'b0, NO_WANT},
        '{1'b0, CFG_NONE, 16'h0, '{16'hFFFF, 1'b1}, 1'b1, '{16'hFFFF, 5'd31, 1'b1, 1'b1}},
        '{1'b1, CFG_FADE_DIRECTION, 16'(FADE_OUT), NO_WORD, 1'b0, NO_WANT},
        '{1'b0, CFG_NONE, 16'h0, '{16'h1234, 1'b0}, 1'b1, '{16'h1234, 5'd31, 1'b0, 1'b0}},
        '{1'b1, CFG_LEVEL_STEP, 16'd0, NO_WORD, 1'b0, NO_WANT},
        '{1'b0, CFG_NONE, 16'h0, '{16'hFFFF, 1'b1}, 1'b0, NO_WANT},
        '{1'b0, CFG_NONE, 16'h0, '{16'h8001, 1'b1}, 1'b0, NO_WANT},
        '{1'b1, CFG_FADE_DIRECTION, 16'(FADE_IN), NO_WORD, 1'b0, NO_WANT},
        '{1'b0, CFG_NONE, 16'h0, '{16'h7FFE, 1'b1}, 1'b0, NO_WANT},
        '{1'b1, CFG_NONE, 16'hFFFF, NO_WORD, 1'b0, NO_WANT},
        '{1'b1, CFG_RED_MASK, 16'hFFFF, NO_WORD, 1'b0, NO_WANT},
        '{1'b1, CFG_GREEN_MASK, 16'h0F0F, NO_WORD, 1'b0, NO_WANT},
        '{1'b1, CFG_BLUE_MASK, 16'hFFFF, NO_WORD, 1'b0, NO_WANT},
        '{1'b1, CFG_RED_SHIFT, 16'd0, NO_WORD, 1'b0, NO_WANT},
        '{1'b1, CFG_GREEN_SHIFT, 16'd15, NO_WORD, 1'b0, NO_WANT},
        '{1'b0, CFG_NONE, 16'h0, '{16'hFFFF, 1'b0}, 1'b0, NO_WANT},
        '{1'b0, CFG_NONE, 16'h0, '{16'h8000, 1'b1}, 1'b0, NO_WANT},
        '{1'b0, CFG_NONE, 16'h0, '{16'h0001, 1'b1}, 1'b0, NO_WANT},
        '{1'b1, CFG_RED_SHIFT, 16'd15, NO_WORD, 1'b0, NO_WANT},
        '{1'b0, CFG_NONE, 16'h0, '{16'h5A5A, 1'b0}, 1'b0, NO_WANT}
    };

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    in_word_t                 in_data   = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    out_word_t                out_data;
    logic                     cfg_we    = 1'b0;
    logic [CfgIndexWidth-1:0] cfg_index = '0;
    logic [15:0]              cfg_data  = '0;

    logic      pin_use  = 1'b0;
    out_word_t pin_want = '0;

    logic [15:0] lay_red_mask;
    logic [15:0] lay_green_mask;
    logic [15:0] lay_blue_mask;
    logic [3:0]  lay_red_shift;
    logic [3:0]  lay_green_shift;
    logic        lay_direction;
    logic [4:0]  lay_step;
    logic [4:0]  fade_lvl;
    logic        fade_idle;

    out_word_t   shaded_due [$];
    int unsigned mismatches   = 0;
    int unsigned cycles       = 0;
    bit          sender_calm  = 1'b0;
    bit          sink_calm    = 1'b0;
    bit          squeeze_req  = 1'b0;
    bit          squeeze_done = 1'b0;

    rgb16_shade_fade dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [15:0] scale_part(input logic [15:0] comp, input logic [4:0] lvl,
                                               input logic [15:0] ceiling);
        longint unsigned i;
        longint unsigned v;
        i = longint'(lvl) + 1;
        v = longint'(comp) * i * (CURVE_BASE + i * (CURVE_SPAN - i)) / CURVE_DIV;
        if (v > longint'(ceiling))
            v = longint'(ceiling);
        return v[15:0];
    endfunction

    function automatic out_word_t shade_word(input in_word_t w);
        out_word_t   res;
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        logic [31:0] packed_px;
        logic [4:0]  lvl;
        int unsigned stride;
        if (fade_idle)
        begin
            fade_idle = 1'b0;
            fade_lvl  = (lay_direction == FADE_OUT) ? LEVEL_TOP : 5'd0;
        end
        lvl = fade_lvl;
        r = scale_part((w.pixel_in & lay_red_mask) >> lay_red_shift, lvl,
                       lay_red_mask >> lay_red_shift);
        g = scale_part((w.pixel_in & lay_green_mask) >> lay_green_shift, lvl,
                       lay_green_mask >> lay_green_shift);
        b = scale_part(w.pixel_in & lay_blue_mask, lvl, lay_blue_mask);
        packed_px = (32'(r) << lay_red_shift) | (32'(g) << lay_green_shift) | 32'(b);
        res.pixel_out  = packed_px[15:0];
        res.level_used = lvl;
        res.frame_last = w.frame_end;
        res.fade_done  = 1'b0;
        if (w.frame_end)
        begin
            stride = (lay_step == 5'd0) ? 1 : int'(lay_step);
            if (lay_direction == FADE_OUT)
            begin
                if (int'(lvl) < stride)
                    res.fade_done = 1'b1;
                else
                    fade_lvl = 5'(int'(lvl) - stride);
            end
            else if (int'(lvl) + stride > int'(LEVEL_TOP))
                res.fade_done = 1'b1;
            else
                fade_lvl = 5'(int'(lvl) + stride);
            if (res.fade_done)
                fade_idle = 1'b1;
        end
        return res;
    endfunction

    function automatic int unsigned pick_gap(input bit calm);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 70)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic note_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_RED_MASK:       lay_red_mask    = val;
            CFG_GREEN_MASK:     lay_green_mask  = val;
            CFG_BLUE_MASK:      lay_blue_mask   = val;
            CFG_RED_SHIFT:      lay_red_shift   = val[3:0];
            CFG_GREEN_SHIFT:    lay_green_shift = val[3:0];
            CFG_FADE_DIRECTION: lay_direction   = val[0];
            CFG_LEVEL_STEP:     lay_step        = val[4:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic offer_word(input in_word_t w, input logic typed, input out_word_t want);
        int unsigned gap;
        gap = pick_gap(sender_calm);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        pin_use  <= typed;
        pin_want <= want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // drop valid, wait for the pipeline to empty
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (shaded_due.size() != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("rgb16_shade_fade regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin : scoreboard
        out_word_t want;
        out_word_t guess;
        if (out_valid && out_ready)
        begin
            if (shaded_due.size() == 0)
            begin
                $display("%0t ns: unexpected word, got %h", $time, out_data);
                mismatches++;
            end
            else
            begin
                want = shaded_due.pop_front();
                note_field("pixel_out", want.pixel_out, out_data.pixel_out);
                note_field("level_used", 16'(want.level_used), 16'(out_data.level_used));
                note_field("frame_last", 16'(want.frame_last), 16'(out_data.frame_last));
                note_field("fade_done", 16'(want.fade_done), 16'(out_data.fade_done));
            end
        end
        if (in_valid && in_ready)
        begin
            guess = shade_word(in_data);
            shaded_due.push_back(pin_use ? pin_want : guess);
        end
    end

    initial
    begin : sink
        int unsigned hold;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (squeeze_req && !squeeze_done)
            begin
                squeeze_done = 1'b1;
                out_ready <= 1'b0;
                repeat (SQUEEZE_CYCLES - 1) @(negedge clk);
            end
            else if (hold != 0)
            begin
                out_ready <= 1'b0;
                hold--;
            end
            else
            begin
                hold = pick_gap(sink_calm);
                if (hold != 0)
                begin
                    out_ready <= 1'b0;
                    hold--;
                end
                else
                    out_ready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        int unsigned phase;
        int unsigned left;
        int unsigned frame_len;
        int unsigned roll;
        in_word_t    w;
        lay_red_mask    = 16'hF800;
        lay_green_mask  = 16'h07E0;
        lay_blue_mask   = 16'h001F;
        lay_red_shift   = 4'd11;
        lay_green_shift = 4'd5;
        lay_direction   = FADE_IN;
        lay_step        = 5'd2;
        fade_lvl        = 5'd0;
        fade_idle       = 1'b1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int n = 0; n < PROBE_ROWS; n++)
        begin
            if (PROBES[n].is_cfg)
            begin
                settle();
                write_reg(PROBES[n].idx, PROBES[n].val);
            end
            else
                offer_word(PROBES[n].word, PROBES[n].typed, PROBES[n].want);
        end

        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            settle();
            case (phase)
                0, 1:
                begin
                    write_reg(CFG_RED_MASK, 16'hF800);
                    write_reg(CFG_GREEN_MASK, 16'h07E0);
                    write_reg(CFG_BLUE_MASK, 16'h001F);
                    write_reg(CFG_RED_SHIFT, 16'd11);
                    write_reg(CFG_GREEN_SHIFT, 16'd5);
                    write_reg(CFG_FADE_DIRECTION, 16'((phase == 0) ? FADE_IN : FADE_OUT));
                    write_reg(CFG_LEVEL_STEP, 16'd1);
                end
                2:
                begin
                    write_reg(CFG_RED_MASK, 16'h7C00);
                    write_reg(CFG_GREEN_MASK, 16'h03E0);
                    write_reg(CFG_BLUE_MASK, 16'h001F);
                    write_reg(CFG_RED_SHIFT, 16'd10);
                    write_reg(CFG_GREEN_SHIFT, 16'd5);
                    write_reg(CFG_FADE_DIRECTION, 16'($urandom_range(0, 1)));
                    write_reg(CFG_LEVEL_STEP, 16'd31);
                end
                3:
                begin
                    write_reg(CFG_RED_MASK, 16'hFFFF);
                    write_reg(CFG_GREEN_MASK, 16'hFFFF);
                    write_reg(CFG_BLUE_MASK, 16'hFFFF);
                    write_reg(CFG_RED_SHIFT, 16'd15);
                    write_reg(CFG_GREEN_SHIFT, 16'd15);
                    write_reg(CFG_FADE_DIRECTION, 16'($urandom_range(0, 1)));
                    write_reg(CFG_LEVEL_STEP, 16'($urandom_range(0, 31)));
                end
                4:
                begin
                    write_reg(CFG_RED_MASK, 16'h0000);
                    write_reg(CFG_GREEN_MASK, 16'h0000);
                    write_reg(CFG_BLUE_MASK, 16'h0000);
                    write_reg(CFG_RED_SHIFT, 16'd0);
                    write_reg(CFG_GREEN_SHIFT, 16'd0);
                    write_reg(CFG_FADE_DIRECTION, 16'($urandom_range(0, 1)));
                    write_reg(CFG_LEVEL_STEP, 16'd0);
                end
                default:
                begin
                    write_reg(CFG_RED_MASK, 16'($urandom_range(0, 65535)));
                    write_reg(CFG_GREEN_MASK, 16'($urandom_range(0, 65535)));
                    write_reg(CFG_BLUE_MASK, 16'($urandom_range(0, 65535)));
                    write_reg(CFG_RED_SHIFT, 16'($urandom_range(0, 15)));
                    write_reg(CFG_GREEN_SHIFT, 16'($urandom_range(0, 15)));
                    write_reg(CFG_FADE_DIRECTION, 16'($urandom_range(0, 1)));
                    write_reg(CFG_LEVEL_STEP, 16'($urandom_range(0, 31)));
                end
            endcase
            sender_calm = (phase == 3) || ($urandom_range(0, 3) == 0);
            sink_calm   = ($urandom_range(0, 3) == 0);
            if (phase == 3)
                squeeze_req = 1'b1;

            left = PHASE_WORDS;
            while (left != 0)
            begin
                frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
                                                        : $urandom_range(1, 6);
                if (frame_len > left)
                    frame_len = left;
                for (int k = 1; k <= frame_len; k++)
                begin
                    roll = $urandom_range(0, 15);
                    w.pixel_in  = (roll == 0) ? 16'h0000 :
                                  (roll == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
                    w.frame_end = (k == frame_len);
                    offer_word(w, 1'b0, NO_WANT);
                end
                left -= frame_len;
            end
        end

        settle();
        if (mismatches == 0)
            $display("rgb16_shade_fade regression: pass");
        else
            $display("rgb16_shade_fade regression: fail");
        $finish;
    end

endmodule
